// ----- src/rrd_pkg.sv -----
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared constants for the radar report deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

  localparam int unsigned STORE_DEPTH = 128;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(STORE_DEPTH + 1);
  // scan and field reads run up to 17 bytes past the last header start
  localparam int unsigned POS_W       = $clog2(STORE_DEPTH + 20);

  localparam int unsigned FIELD_BYTES = 13;
  localparam int unsigned FIELD_W     = 8 * FIELD_BYTES;
  localparam int unsigned FIELD_CNT_W = $clog2(FIELD_BYTES);

  localparam logic [31:0] TAIL_WORD   = 32'hF8F7F6F5;
  localparam logic [31:0] HEAD_WORD   = 32'hF4F3F2F1;
  localparam logic [7:0]  PAYLOAD_B0  = 8'h02;
  localparam logic [7:0]  PAYLOAD_B1  = 8'hAA;
  localparam logic [15:0] MIN_LEN     = 16'd13;

endpackage

`default_nettype wire

// ----- src/rrd_if.sv -----
// ----------------------------------------------------------------------------
// rrd_in_if / rrd_out_if
// Valid/ready channels for received bytes and decoded reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  target_kind;
  logic [15:0] moving_distance;
  logic [7:0]  mov_energy;
  logic [15:0] still_distance;
  logic [7:0]  stat_energy;
  logic [15:0] detection_distance;

  modport source (output valid, output target_kind, output moving_distance,
                  output mov_energy, output still_distance, output stat_energy,
                  output detection_distance, input ready);
  modport sink   (input valid, input target_kind, input moving_distance,
                  input mov_energy, input still_distance, input stat_energy,
                  input detection_distance, output ready);
endinterface

`default_nettype wire

// ----- src/radar_report_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// radar_report_deframer_unit
// Byte-at-a-time deframer for radar report frames.
// ----------------------------------------------------------------------------
// Each received byte is written to a 128-byte store.
// When the byte completes an F8 F7 F6 F5 tail, the block stops taking bytes
// and streams the store through its single read port, one byte per cycle,
// to find the first F4 F3 F2 F1 header, then reads the length and the
// eleven payload bytes that follow it, and then takes bytes again once the
// report is emitted or dropped, or once the scan finds no header that
// qualifies. A decoded report waits in an output register, so bytes keep
// flowing while it is not yet taken; only a second report that finds it
// still occupied holds the input until it is.
// The store has a valid bit per entry, so no clearing pass follows reset.
`default_nettype none

module radar_report_deframer_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rrd_in_if.sink     in_i,
  rrd_out_if.source  out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIELD,
    S_EMIT
  } state_e;

  state_e                          state_q;
  logic [rrd_pkg::FILL_W-1:0]      fill_q;
  logic [23:0]                     tail_q;
  logic [rrd_pkg::POS_W-1:0]       addr_q;
  logic [rrd_pkg::POS_W-1:0]       idx_q;
  logic                            live_q;
  logic [23:0]                     win_q;
  logic [rrd_pkg::FIELD_W-1:0]     fld_q;
  logic [rrd_pkg::FIELD_CNT_W-1:0] fcnt_q;

  logic [7:0]                      mem_q [rrd_pkg::STORE_DEPTH];
  logic [rrd_pkg::STORE_DEPTH-1:0] vld_q;
  logic [7:0]                      rdata_q;
  logic                            rd_ok_q;

  logic                            out_valid_q;
  logic [7:0]                      kind_q;
  logic [15:0]                     mdist_q;
  logic [7:0]                      meng_q;
  logic [15:0]                     sdist_q;
  logic [7:0]                      seng_q;
  logic [15:0]                     ddist_q;

  // ---------------------------------------------------------------- datapath
  logic                            accept;
  logic [rrd_pkg::FILL_W-1:0]      fill_base;
  logic [rrd_pkg::FILL_W-1:0]      fill_next;
  logic                            tail_hit;
  logic [7:0]                      cur_byte;
  logic [31:0]                     win_d;
  logic [rrd_pkg::POS_W:0]         idx_plus;
  logic                            pos_room;
  logic                            head_hit;
  logic [rrd_pkg::FIELD_W-1:0]     fld_d;
  logic [7:0]                      fb [rrd_pkg::FIELD_BYTES];
  logic [15:0]                     plen;
  logic                            pay_ok;
  logic                            slot_free;
  logic                            emit;

  assign accept    = in_i.valid && in_i.ready;
  assign fill_base = (fill_q == rrd_pkg::FILL_W'(rrd_pkg::STORE_DEPTH)) ? '0 : fill_q;
  assign fill_next = fill_base + rrd_pkg::FILL_W'(1);
  assign tail_hit  = (fill_next >= rrd_pkg::FILL_W'(4)) &&
                     ({tail_q, in_i.rx_byte} == rrd_pkg::TAIL_WORD);

  assign cur_byte  = rd_ok_q ? rdata_q : 8'h00;
  assign win_d     = {win_q, cur_byte};
  // header at idx-3 qualifies while idx-3+8 < fill
  assign idx_plus  = {1'b0, idx_q} + (rrd_pkg::POS_W + 1)'(5);
  assign pos_room  = idx_plus < (rrd_pkg::POS_W + 1)'(fill_q);
  assign head_hit  = (idx_q >= rrd_pkg::POS_W'(3)) && pos_room &&
                     (win_d == rrd_pkg::HEAD_WORD);
  assign fld_d     = {fld_q[rrd_pkg::FIELD_W-9:0], cur_byte};

  // first byte after the header sits highest in the field register
  always_comb begin
    for (int j = 0; j < rrd_pkg::FIELD_BYTES; j++) begin
      fb[j] = fld_q[(rrd_pkg::FIELD_BYTES-1-j)*8 +: 8];
    end
  end

  assign plen      = {fb[1], fb[0]};
  assign pay_ok    = (plen >= rrd_pkg::MIN_LEN) && (fb[2] == rrd_pkg::PAYLOAD_B0) &&
                     (fb[3] == rrd_pkg::PAYLOAD_B1);
  assign slot_free = !out_valid_q || out_o.ready;
  assign emit      = (state_q == S_EMIT) && pay_ok && slot_free;

  assign in_i.ready = (state_q == S_IDLE);

  // ------------------------------------------------------------------ store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[fill_base[rrd_pkg::ADDR_W-1:0]] <= in_i.rx_byte;
    end
    rdata_q <= mem_q[addr_q[rrd_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (accept) begin
        vld_q[fill_base[rrd_pkg::ADDR_W-1:0]] <= 1'b1;
      end
      rd_ok_q <= (addr_q < rrd_pkg::POS_W'(rrd_pkg::STORE_DEPTH)) &&
                 vld_q[addr_q[rrd_pkg::ADDR_W-1:0]];
    end
  end

  // --------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      tail_q      <= '0;
      addr_q      <= '0;
      idx_q       <= '0;
      live_q      <= 1'b0;
      win_q       <= '0;
      fld_q       <= '0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= '0;
      mdist_q     <= '0;
      meng_q      <= '0;
      sdist_q     <= '0;
      seng_q      <= '0;
      ddist_q     <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            fill_q <= fill_next;
            tail_q <= {tail_q[15:0], in_i.rx_byte};
            if (tail_hit) begin
              state_q <= S_SCAN;
              addr_q  <= '0;
              idx_q   <= '0;
              live_q  <= 1'b0;
            end
          end
        end

        S_SCAN: begin
          // read data arrives in the cycle after its address
          addr_q <= addr_q + rrd_pkg::POS_W'(1);
          live_q <= 1'b1;
          if (live_q) begin
            win_q <= win_d[23:0];
            idx_q <= idx_q + rrd_pkg::POS_W'(1);
            if (head_hit) begin
              state_q <= S_FIELD;
              fcnt_q  <= '0;
            end else if ((idx_q >= rrd_pkg::POS_W'(3)) && !pos_room) begin
              state_q <= S_IDLE;
              fill_q  <= '0;
              tail_q  <= '0;
            end
          end
        end

        S_FIELD: begin
          addr_q <= addr_q + rrd_pkg::POS_W'(1);
          fld_q  <= fld_d;
          fcnt_q <= fcnt_q + rrd_pkg::FIELD_CNT_W'(1);
          if (fcnt_q == rrd_pkg::FIELD_CNT_W'(rrd_pkg::FIELD_BYTES - 1)) begin
            state_q <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (!pay_ok) begin
            state_q <= S_IDLE;
            fill_q  <= '0;
            tail_q  <= '0;
          end else if (slot_free) begin
            state_q     <= S_IDLE;
            fill_q      <= '0;
            tail_q      <= '0;
            kind_q      <= fb[4];
            if (fb[4] == 8'h00) begin
              mdist_q <= '0;
              meng_q  <= '0;
              sdist_q <= '0;
              seng_q  <= '0;
              ddist_q <= '0;
            end else begin
              mdist_q <= {fb[6], fb[5]};
              meng_q  <= fb[7];
              sdist_q <= {fb[9], fb[8]};
              seng_q  <= fb[10];
              ddist_q <= {fb[12], fb[11]};
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.target_kind        = kind_q;
  assign out_o.moving_distance    = mdist_q;
  assign out_o.mov_energy         = meng_q;
  assign out_o.still_distance     = sdist_q;
  assign out_o.stat_energy        = seng_q;
  assign out_o.detection_distance = ddist_q;

endmodule

`default_nettype wire

// ----- sim/tb_radar_report_deframer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radar_report_deframer_unit
// Self-checking bench for the radar report deframer.
// ----------------------------------------------------------------------------
// Received bytes are pushed in over the input channel. Each accepted byte is
// also fed to a byte-level predictor of the deframer, which queues the
// report that a completed frame should yield. Reports taken from the output
// channel are checked field by field against that queue. Stimulus is a short
// run of hand-built frames, then random frames mixed with noise, broken and
// truncated frames and store overruns. Both sides idle at random, and once
// the output side holds off long enough for the block to back up.
// ----------------------------------------------------------------------------

module tb_radar_report_deframer_unit;

  localparam int unsigned RANDOM_BYTES  = 1100;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned IDLE_LIMIT    = 12000;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned MAX_SHOWN     = 10;

  localparam logic [7:0] TARGET_NONE   = 8'd0;
  localparam logic [7:0] TARGET_MOVING = 8'd1;
  localparam logic [7:0] TARGET_STILL  = 8'd2;
  localparam logic [7:0] TARGET_BOTH   = 8'd3;

  typedef struct packed {
    logic [7:0]  kind;
    logic [15:0] mdist;
    logic [7:0]  menergy;
    logic [15:0] sdist;
    logic [7:0]  senergy;
    logic [15:0] ddist;
  } report_t;

  // Byte-level model of the deframer plus the queue of reports still owed.
  class report_scoreboard;
    logic [7:0]  store [rrd_pkg::STORE_DEPTH];
    int unsigned fill;
    report_t     due [$];
    int unsigned predicted;
    int unsigned faults;

    function new();
      foreach (store[i]) store[i] = 8'h00;
      fill      = 0;
      predicted = 0;
      faults    = 0;
    endfunction

    // positions past the end of the store read as zero
    function logic [7:0] byte_at(int unsigned p);
      return (p < rrd_pkg::STORE_DEPTH) ? store[p] : 8'h00;
    endfunction

    function logic [31:0] word_at(int unsigned p);
      return {byte_at(p), byte_at(p + 1), byte_at(p + 2), byte_at(p + 3)};
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned p;
      int unsigned base;
      logic [15:0] len;
      report_t     r;
      if (fill >= rrd_pkg::STORE_DEPTH) fill = 0;
      store[fill] = b;
      fill++;
      if (fill < 4 || word_at(fill - 4) != rrd_pkg::TAIL_WORD) return;
      // only the first qualifying header is tried
      for (p = 0; p + 8 < fill; p++) begin
        if (word_at(p) == rrd_pkg::HEAD_WORD) begin
          len  = {byte_at(p + 5), byte_at(p + 4)};
          base = p + 6;
          if (len >= rrd_pkg::MIN_LEN && byte_at(base) == rrd_pkg::PAYLOAD_B0 &&
              byte_at(base + 1) == rrd_pkg::PAYLOAD_B1) begin
            r      = '0;
            r.kind = byte_at(base + 2);
            if (r.kind != TARGET_NONE) begin
              r.mdist   = {byte_at(base + 4), byte_at(base + 3)};
              r.menergy = byte_at(base + 5);
              r.sdist   = {byte_at(base + 7), byte_at(base + 6)};
              r.senergy = byte_at(base + 8);
              r.ddist   = {byte_at(base + 10), byte_at(base + 9)};
            end
            due.push_back(r);
            predicted++;
          end
          break;
        end
      end
      fill = 0;
    endfunction

    function string show(report_t r);
      return $sformatf("kind=%h md=%h me=%h sd=%h se=%h dd=%h", r.kind, r.mdist,
                       r.menergy, r.sdist, r.senergy, r.ddist);
    endfunction

    function void note_fault(string what);
      faults++;
      if (faults <= MAX_SHOWN) $display("[%0t] %s", $realtime, what);
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (due.size() == 0) begin
        note_fault({"report with none due: ", show(got)});
        return;
      end
      want = due.pop_front();
      if (got.kind != want.kind || got.mdist != want.mdist ||
          got.menergy != want.menergy || got.sdist != want.sdist ||
          got.senergy != want.senergy || got.ddist != want.ddist)
        note_fault({"report mismatch: expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rrd_in_if  in_bus ();
  rrd_out_if out_bus ();

  radar_report_deframer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  report_scoreboard sb = new();

  int unsigned bytes_sent;
  bit          steady;
  bit          hold_output;
  report_t     seen;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [15:0] rand_dist();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 800));
    endcase
  endfunction

  function automatic logic [7:0] rand_energy();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
  endfunction

  function automatic report_t random_report();
    report_t     r;
    int unsigned k;
    k = $urandom_range(0, 9);
    r.kind    = (k < 7) ? 8'($urandom_range(1, 3)) :
                (k < 9) ? TARGET_NONE : 8'($urandom);
    r.mdist   = rand_dist();
    r.menergy = rand_energy();
    r.sdist   = rand_dist();
    r.senergy = rand_energy();
    r.ddist   = rand_dist();
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_byte(b);
    bytes_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // most significant byte goes first, so the marker words read in wire order
  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [7:0] id0,
                            input logic [7:0] id1, input report_t r,
                            input int unsigned extra);
    send_word(rrd_pkg::HEAD_WORD);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(id0);
    send_byte(id1);
    send_byte(r.kind);
    send_byte(r.mdist[7:0]);
    send_byte(r.mdist[15:8]);
    send_byte(r.menergy);
    send_byte(r.sdist[7:0]);
    send_byte(r.sdist[15:8]);
    send_byte(r.senergy);
    send_byte(r.ddist[7:0]);
    send_byte(r.ddist[15:8]);
    repeat (extra) send_byte(8'($urandom));
    send_word(rrd_pkg::TAIL_WORD);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned extra;
    logic [15:0] len;
    logic [7:0]  id0;
    logic [7:0]  id1;
    pick = $urandom_range(0, 99);
    id0  = rrd_pkg::PAYLOAD_B0;
    id1  = rrd_pkg::PAYLOAD_B1;
    len  = ($urandom_range(0, 3) != 0) ? rrd_pkg::MIN_LEN : 16'($urandom_range(14, 24));
    if (pick < 8)       len = 16'($urandom_range(0, 12));
    else if (pick < 12) id0 = 8'($urandom);
    else if (pick < 16) id1 = 8'($urandom);
    else if (pick < 18) len = 16'($urandom);
    extra = (len >= rrd_pkg::MIN_LEN && len <= 16'd24) ? 32'(len - rrd_pkg::MIN_LEN) :
            $urandom_range(0, 4);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    send_frame(len, id0, id1, random_report(), extra);
  endtask

  task automatic run_directed();
    // tail with no header in front of it
    send_byte(8'h00);
    send_byte(8'hFF);
    send_word(rrd_pkg::TAIL_WORD);
    // no target: fields in the frame are not passed on
    send_frame(rrd_pkg::MIN_LEN, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
               '{TARGET_NONE, 16'h1234, 8'h56, 16'h789A, 8'hBC, 16'hDEF0}, 0);
    send_frame(rrd_pkg::MIN_LEN, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
               '{TARGET_MOVING, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF}, 0);
    send_frame(16'hFFFF, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
               '{TARGET_STILL, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000}, 0);
    send_frame(16'd15, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
               '{TARGET_BOTH, 16'd150, 8'd60, 16'd75, 8'd40, 16'd150}, 2);
    send_frame(rrd_pkg::MIN_LEN, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
               '{8'hFF, 16'h0001, 8'h80, 16'h8000, 8'h01, 16'h7FFF}, 0);
    // short length, then wrong payload id bytes
    send_frame(rrd_pkg::MIN_LEN - 16'd1, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
               random_report(), 0);
    send_frame(rrd_pkg::MIN_LEN, 8'h03, rrd_pkg::PAYLOAD_B1, random_report(), 0);
    send_frame(rrd_pkg::MIN_LEN, rrd_pkg::PAYLOAD_B0, 8'hAB, random_report(), 0);
    // header too close to the tail to count
    send_word(rrd_pkg::HEAD_WORD);
    send_word(rrd_pkg::TAIL_WORD);
    // payload runs past the fill into stale bytes
    send_word(rrd_pkg::HEAD_WORD);
    send_byte(rrd_pkg::MIN_LEN[7:0]);
    send_byte(rrd_pkg::MIN_LEN[15:8]);
    send_byte(rrd_pkg::PAYLOAD_B0);
    send_byte(rrd_pkg::PAYLOAD_B1);
    send_word(rrd_pkg::TAIL_WORD);
    // first header is short, the good one behind it is never tried
    send_word(rrd_pkg::HEAD_WORD);
    send_byte(8'h05);
    send_byte(8'h00);
    send_frame(rrd_pkg::MIN_LEN, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
               random_report(), 0);
    // overrun the store, then a good frame
    for (int i = 0; i < 130; i++) send_byte(8'(i) & 8'h7F);
    send_frame(rrd_pkg::MIN_LEN, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
               random_report(), 0);
    // header near the top: payload reads run past the end of the store
    repeat (116) send_byte(8'h5A);
    send_word(rrd_pkg::HEAD_WORD);
    send_byte(rrd_pkg::MIN_LEN[7:0]);
    send_byte(rrd_pkg::MIN_LEN[15:8]);
    send_byte(rrd_pkg::PAYLOAD_B0);
    send_byte(rrd_pkg::PAYLOAD_B1);
    send_word(rrd_pkg::TAIL_WORD);
  endtask

  task automatic run_random();
    int unsigned first_byte;
    int unsigned r;
    bit          pressed;
    first_byte = bytes_sent;
    pressed    = 1'b0;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      steady = (bytes_sent - first_byte >= 600) && (bytes_sent - first_byte < 800);
      if (!pressed && bytes_sent - first_byte >= 400) begin
        // output side stalls; good frames keep coming until the input backs up
        pressed     = 1'b1;
        hold_output = 1'b1;
        repeat (4) send_frame(rrd_pkg::MIN_LEN, rrd_pkg::PAYLOAD_B0, rrd_pkg::PAYLOAD_B1,
                              random_report(), 0);
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_random_frame();
      end else if (r < 85) begin
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
      end else if (r < 92) begin
        // truncated frame: header left behind in the store
        send_word(rrd_pkg::HEAD_WORD);
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
      end else if (r < 99) begin
        send_word(rrd_pkg::TAIL_WORD);
      end else begin
        repeat ($urandom_range(125, 140)) send_byte(8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // output side: random ready stretches and gaps, one long hold on request
  initial begin
    int unsigned gap;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end else if (steady) begin
        out_bus.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        gap = pick_gap();
        if (gap != 0) begin
          out_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      seen = '{kind:    out_bus.target_kind,
               mdist:   out_bus.moving_distance,
               menergy: out_bus.mov_energy,
               sdist:   out_bus.still_distance,
               senergy: out_bus.stat_energy,
               ddist:   out_bus.detection_distance};
      sb.check_report(seen);
    end
  end

  // watchdog: cycles with no transfer on either side
  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("tb_radar_report_deframer_unit: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= 8'h00;
    bytes_sent  = 0;
    steady      = 1'b0;
    hold_output = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_bus.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.faults == 0) $display("tb_radar_report_deframer_unit: clean");
    else $display("tb_radar_report_deframer_unit: errors");
    $finish;
  end

endmodule
